// ===== rtl/kpec_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kpec_pkg
// shared types and constants for the key press event classifier
// ----------------------------------------------------------------------------
package kpec_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int THRESH_W        = 16;
    localparam int MODE_W          = 8;
    localparam int CFG_DATA_W      = 16;
    localparam int HOLD_OUT_W      = 16;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET  = 16'd100;
    localparam logic [MODE_W-1:0]   MODE_LIMIT_RESET = 8'd9;

    typedef enum logic {
        CFG_LONG_THRESHOLD = 1'b0,
        CFG_MODE_LIMIT     = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic              level;
        logic              standby;
        logic [MODE_W-1:0] mode;
    } t_kpec_state;

    typedef struct packed {
        logic                  just_pressed;
        logic                  just_released;
        logic                  long_holding;
        logic                  long_released;
        logic [HOLD_OUT_W-1:0] hold_count;
        logic [MODE_W-1:0]     current_mode;
        logic                  standby_request;
    } t_kpec_result;

endpackage : kpec_pkg
`default_nettype wire

// ===== rtl/kpec_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kpec_core
// per-tick update: edge detect, hold count, mode step and standby flag
// ----------------------------------------------------------------------------
module kpec_core
    import kpec_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   i_key_pressed,
    input  wire logic                   i_clear_standby,
    input  wire t_kpec_state            i_state,
    input  wire logic [COUNT_WIDTH-1:0] i_count,
    input  wire logic [THRESH_W-1:0]    i_long_threshold,
    input  wire logic [MODE_W-1:0]      i_mode_limit,
    output t_kpec_state                 o_state,
    output logic [COUNT_WIDTH-1:0]      o_count,
    output t_kpec_result                o_result
);

    localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

    logic              rise;
    logic              fall;
    logic              long_hold;
    logic              old_long;
    logic              long_rel;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  old_ext;
    logic [CMP_W-1:0]  thr_ext;
    logic [MODE_W:0]   mode_inc;
    logic [MODE_W-1:0] mode_next;
    logic              standby_next;

    always_comb begin
        if (!i_key_pressed) begin
            o_count = '0;
        end else if (&i_count) begin
            o_count = i_count;
        end else begin
            o_count = i_count + COUNT_WIDTH'(1);
        end
    end

    assign rise      = i_key_pressed & ~i_state.level;
    assign fall      = ~i_key_pressed & i_state.level;
    assign cnt_ext   = CMP_W'(o_count);
    assign old_ext   = CMP_W'(i_count);
    assign thr_ext   = CMP_W'(i_long_threshold);
    assign long_hold = (cnt_ext >= thr_ext);
    assign old_long  = (old_ext >= thr_ext);
    assign long_rel  = fall & old_long;

    assign mode_inc = {1'b0, i_state.mode} + (MODE_W+1)'(1);

    always_comb begin
        if (fall && !old_long) begin
            if (mode_inc >= {1'b0, i_mode_limit}) begin
                mode_next = '0;
            end else begin
                mode_next = mode_inc[MODE_W-1:0];
            end
        end else begin
            mode_next = i_state.mode;
        end
    end

    assign standby_next = (i_state.standby & ~i_clear_standby) | long_rel;

    always_comb begin
        o_state.level   = i_key_pressed;
        o_state.standby = standby_next;
        o_state.mode    = mode_next;

        o_result.just_pressed    = rise;
        o_result.just_released   = fall;
        o_result.long_holding    = long_hold;
        o_result.long_released   = long_rel;
        o_result.hold_count      = cnt_ext[HOLD_OUT_W-1:0];
        o_result.current_mode    = mode_next;
        o_result.standby_request = standby_next;
    end

endmodule : kpec_core
`default_nettype wire

// ===== rtl/key_press_event_classifier_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_press_event_classifier_unit
// short and long press classifier for one sampled touch key
// ----------------------------------------------------------------------------
// Each input beat is one sampling tick of the key level and gives exactly one
// output beat with press/release edges, long hold and long release flags, the
// saturating hold count, the mode counter and the sticky standby request.
// One beat per clock is sustained: the tick update is a single compare and
// increment stage that feeds the output register, so a beat is accepted every
// cycle while the output register is empty or being drained. The user must
// write configuration through the plain write port while idle (not enforced).
// ----------------------------------------------------------------------------
module key_press_event_classifier_unit
    import kpec_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_key_pressed,
    input  wire logic                  i_clear_standby,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_just_pressed,
    output logic                       o_just_released,
    output logic                       o_long_holding,
    output logic                       o_long_released,
    output logic [HOLD_OUT_W-1:0]      o_hold_count,
    output logic [MODE_W-1:0]          o_current_mode,
    output logic                       o_standby_request
);

    logic [THRESH_W-1:0]    r_long_threshold;
    logic [MODE_W-1:0]      r_mode_limit;
    t_kpec_state            r_state;
    t_kpec_state            n_state;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    t_kpec_result           r_result;
    t_kpec_result           n_result;
    logic                   r_out_valid;
    logic                   accept;
    t_cfg_index             cfg_idx;

    assign cfg_idx = t_cfg_index'(i_cfg_addr);
    assign o_ready = ~r_out_valid | i_ready;
    assign accept  = i_valid & o_ready;

    kpec_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_key_pressed    (i_key_pressed),
        .i_clear_standby  (i_clear_standby),
        .i_state          (r_state),
        .i_count          (r_count),
        .i_long_threshold (r_long_threshold),
        .i_mode_limit     (r_mode_limit),
        .o_state          (n_state),
        .o_count          (n_count),
        .o_result         (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_threshold <= THRESHOLD_RESET;
            r_mode_limit     <= MODE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (cfg_idx)
                CFG_LONG_THRESHOLD: r_long_threshold <= i_cfg_data[THRESH_W-1:0];
                CFG_MODE_LIMIT:     r_mode_limit     <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
                r_count <= n_count;
            end
            r_out_valid <= accept | (r_out_valid & ~i_ready);
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_just_pressed    = r_result.just_pressed;
    assign o_just_released   = r_result.just_released;
    assign o_long_holding    = r_result.long_holding;
    assign o_long_released   = r_result.long_released;
    assign o_hold_count      = r_result.hold_count;
    assign o_current_mode    = r_result.current_mode;
    assign o_standby_request = r_result.standby_request;

    a_edges_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_just_pressed && o_just_released))
        else $error("press and release edge in one beat");

    a_long_rel_is_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_long_released) |-> (o_just_released && o_standby_request))
        else $error("long release without release edge or standby");

    a_release_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_key_pressed) |=> (r_count == '0 && !r_state.level))
        else $error("hold count not cleared on release");

    a_press_starts_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_just_pressed) |-> (o_hold_count == HOLD_OUT_W'(1)))
        else $error("hold count not one on press edge");

endmodule : key_press_event_classifier_unit
`default_nettype wire

// ===== sim/key_press_event_classifier_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_press_event_classifier_unit_tb
// self-checking bench for the short and long press classifier
// ----------------------------------------------------------------------------
// Sampling ticks are queued by the stimulus process and driven over the
// valid/ready input channel. Every accepted tick runs through a local model
// of the classifier, and every output beat is compared field by field with
// the oldest predicted result. Directed ticks cover edges, the zero
// threshold, mode wrap and clear-with-long-release. A full-rate hold at the
// top threshold never turns long. Random press/release traffic then runs under
// changing thresholds and mode limits, with random gaps on both sides, one
// long receiver stall and full-rate stretches.
// ----------------------------------------------------------------------------
module key_press_event_classifier_unit_tb;
    import kpec_pkg::*;

    localparam int COUNT_W        = COUNT_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 300;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_TICKS    = 90;

    typedef struct {
        logic        key;
        logic        clr;
        int unsigned gap;
    } t_key_tick;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic                  i_cfg_addr      = CFG_LONG_THRESHOLD;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_valid         = 1'b0;
    logic                  i_key_pressed   = 1'b0;
    logic                  i_clear_standby = 1'b0;
    logic                  i_ready         = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic                  o_just_pressed;
    logic                  o_just_released;
    logic                  o_long_holding;
    logic                  o_long_released;
    logic [HOLD_OUT_W-1:0] o_hold_count;
    logic [MODE_W-1:0]     o_current_mode;
    logic                  o_standby_request;

    // local copy of the classifier state and registers
    logic [THRESH_W-1:0] cfg_long_thresh = THRESHOLD_RESET;
    logic [MODE_W-1:0]   cfg_mode_limit  = MODE_LIMIT_RESET;
    logic                key_level_q     = 1'b0;
    logic [COUNT_W-1:0]  hold_ticks      = '0;
    logic [MODE_W-1:0]   mode_q          = '0;
    logic                standby_q       = 1'b0;

    t_key_tick    tick_queue[$];
    t_kpec_result pending_events[$];

    logic        tx_quiet    = 1'b0;
    logic        rx_quiet    = 1'b0;
    int          rx_hold_req = 0;
    int          rx_hold_ack = 0;
    int unsigned gap_count   = 0;
    int unsigned ready_wait  = 0;
    int unsigned hold_left   = 0;
    int          idle_cycles = 0;

    int error_count     = 0;
    int ticks_sent      = 0;
    int beats_checked   = 0;
    int long_releases   = 0;
    int mode_wraps      = 0;
    int settings_used   = 0;

    t_key_tick    next_tick;
    t_kpec_result want;
    int unsigned  wait_next;
    int unsigned  hold_next;
    logic         ready_next;

    key_press_event_classifier_unit #(
        .COUNT_WIDTH (COUNT_W)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_key_pressed     (i_key_pressed),
        .i_clear_standby   (i_clear_standby),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_just_pressed    (o_just_pressed),
        .o_just_released   (o_just_released),
        .o_long_holding    (o_long_holding),
        .o_long_released   (o_long_released),
        .o_hold_count      (o_hold_count),
        .o_current_mode    (o_current_mode),
        .o_standby_request (o_standby_request)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_kpec_result classify_tick(input logic key, input logic clr);
        t_kpec_result       res;
        logic [COUNT_W-1:0] prior;
        logic [MODE_W:0]    mode_inc;
        prior = hold_ticks;
        if (clr) begin
            standby_q = 1'b0;
        end
        if (key) begin
            if (hold_ticks != '1) begin
                hold_ticks = hold_ticks + 1'b1;
            end
        end else begin
            hold_ticks = '0;
        end
        res.just_pressed  = key && !key_level_q;
        res.just_released = !key && key_level_q;
        res.long_holding  = (hold_ticks >= cfg_long_thresh);
        res.long_released = res.just_released && (prior >= cfg_long_thresh);
        if (res.just_released && (prior < cfg_long_thresh)) begin
            mode_inc = {1'b0, mode_q} + 1'b1;
            if (mode_inc >= {1'b0, cfg_mode_limit}) begin
                mode_inc = '0;
                mode_wraps++;
            end
            mode_q = mode_inc[MODE_W-1:0];
        end
        if (res.long_released) begin
            standby_q = 1'b1;
            long_releases++;
        end
        key_level_q         = key;
        res.hold_count      = hold_ticks[HOLD_OUT_W-1:0];
        res.current_mode    = mode_q;
        res.standby_request = standby_q;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid         <= 1'b0;
            i_key_pressed   <= 1'b0;
            i_clear_standby <= 1'b0;
            gap_count       <= 0;
        end else begin
            if (i_valid && o_ready) begin
                pending_events.push_back(classify_tick(i_key_pressed, i_clear_standby));
                ticks_sent++;
            end
            if (!i_valid || o_ready) begin
                if (tick_queue.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (gap_count < tick_queue[0].gap) begin
                    gap_count <= gap_count + 1;
                    i_valid   <= 1'b0;
                end else begin
                    next_tick        = tick_queue.pop_front();
                    i_valid         <= 1'b1;
                    i_key_pressed   <= next_tick.key;
                    i_clear_standby <= next_tick.clr;
                    gap_count       <= 0;
                end
            end
        end
    end

    // output monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            ready_wait <= 0;
            hold_left  <= 0;
        end else begin
            wait_next = ready_wait;
            hold_next = hold_left;
            if (o_valid && i_ready) begin
                if (pending_events.size() == 0) begin
                    $error("result beat with no tick pending");
                    error_count++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("just_pressed", want.just_pressed, o_just_pressed);
                    check_field("just_released", want.just_released, o_just_released);
                    check_field("long_holding", want.long_holding, o_long_holding);
                    check_field("long_released", want.long_released, o_long_released);
                    check_field("hold_count", want.hold_count, o_hold_count);
                    check_field("current_mode", want.current_mode, o_current_mode);
                    check_field("standby_request", want.standby_request,
                                o_standby_request);
                    beats_checked++;
                end
                wait_next = rx_quiet ? 0 : $urandom_range(0, 15);
            end
            if (rx_hold_ack != rx_hold_req) begin
                rx_hold_ack <= rx_hold_req;
                hold_next = LONG_STALL;
            end
            if (hold_next > 0) begin
                hold_next--;
                ready_next = 1'b0;
            end else if (wait_next > 0) begin
                wait_next--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            hold_left  <= hold_next;
            ready_wait <= wait_next;
            i_ready    <= ready_next;
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("key_press_event_classifier_unit_tb: FAIL");
        $finish;
    end

    task automatic push_tick(input logic key, input logic clr);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        tick_queue.push_back('{key, clr, gap});
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (tick_queue.size() != 0 || i_valid || pending_events.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LONG_THRESHOLD) begin
            cfg_long_thresh = data[THRESH_W-1:0];
        end else begin
            cfg_mode_limit = data[MODE_W-1:0];
        end
    endtask

    // wait for an idle block, then load both registers and the idle pattern
    task automatic start_phase(input logic [THRESH_W-1:0] thresh,
                               input logic [MODE_W-1:0] limit,
                               input logic tx_q, input logic rx_q);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        drain();
        repeat (2) @(negedge i_clk);
        write_reg(CFG_LONG_THRESHOLD, thresh);
        write_reg(CFG_MODE_LIMIT, {junk, limit});
        @(negedge i_clk);
        tx_quiet = tx_q;
        rx_quiet = rx_q;
        settings_used++;
    endtask

    // press runs around the threshold with release runs, plus noise ticks
    task automatic push_key_traffic(input int count);
        int queued;
        int run_len;
        int cap;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(0, 4) == 0) begin
                push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                queued++;
            end else begin
                cap = (cfg_long_thresh < 36) ? int'(cfg_long_thresh) + 4 : 40;
                run_len = int'($urandom_range(1, cap));
                repeat (run_len) push_tick(1'b1, $urandom_range(0, 7) == 0);
                queued += run_len;
                run_len = int'($urandom_range(1, 5));
                repeat (run_len) push_tick(1'b0, $urandom_range(0, 7) == 0);
                queued += run_len;
            end
        end
    endtask

    initial begin
        logic [THRESH_W-1:0] thresh;
        logic [MODE_W-1:0]   limit;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: short releases and a clear with nothing set
        @(negedge i_clk);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);

        // zero threshold: every release is long, clear and long release together
        start_phase(16'd0, 8'd255, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b1);

        // limit of one wraps at once, then a long release at the threshold
        start_phase(16'd3, 8'd1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        repeat (3) push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);

        // limit below the current mode, then a zero limit
        start_phase(16'd100, 8'd9, 1'b1, 1'b1);
        repeat (2) begin
            push_tick(1'b1, 1'b0);
            push_tick(1'b0, 1'b0);
        end
        start_phase(16'd100, 8'd1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        start_phase(16'd100, 8'd0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);

        // full-rate hold at the top threshold stays short
        start_phase(16'hFFFF, 8'd255, 1'b1, 1'b1);
        repeat (20) push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       thresh = 16'd0;
                1:       thresh = 16'hFFFF;
                default: thresh = THRESH_W'($urandom_range(1, 20));
            endcase
            case ($urandom_range(0, 4))
                0:       limit = 8'd1;
                1:       limit = 8'd255;
                default: limit = MODE_W'($urandom_range(2, 12));
            endcase
            if (phase == 2) begin
                // receiver holds off while the sender keeps offering ticks
                start_phase(thresh, limit, 1'b1, 1'b0);
                push_key_traffic(PHASE_TICKS);
                rx_hold_req++;
            end else begin
                start_phase(thresh, limit, $urandom_range(0, 3) == 0,
                            $urandom_range(0, 3) == 0);
                push_key_traffic(PHASE_TICKS);
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("covered %0d ticks and %0d checked beats under %0d register settings",
                 ticks_sent, beats_checked, settings_used);
        $display("saw %0d long releases and %0d mode wraps, with one long receiver stall",
                 long_releases, mode_wraps);
        if (error_count == 0) begin
            $display("key_press_event_classifier_unit_tb: PASS");
        end else begin
            $display("key_press_event_classifier_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kpec_pkg.sv
rtl/kpec_core.sv
rtl/key_press_event_classifier_unit.sv
sim/key_press_event_classifier_unit_tb.sv
